### src/bavg_pkg.sv
// Shared constants, codes and control types for the battery average alarm.
package bavg_pkg;

  // Window depth (power of two) and output code range
  localparam int HISTORY_DEPTH = 16;
  localparam int OUT_MAX       = 1023;
  localparam int OUT_MIN       = 0;

  // Field and register widths
  localparam int RAW_W     = 10;
  localparam int TRIM_W    = 11;
  localparam int SPAN_W    = 10;
  localparam int OUT_W     = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  // Ring and running sum
  localparam int HIST_AW = $clog2(HISTORY_DEPTH);
  localparam int SUM_W   = OUT_W + HIST_AW;

  // Mapping arithmetic: trimmed offset, span, magnitudes, product, quotient
  localparam int D_W       = RAW_W + 2;
  localparam int DEN_W     = SPAN_W + 1;
  localparam int DMAG_W    = D_W - 1;
  localparam int SMAG_W    = SPAN_W;
  localparam int OUT_RANGE = OUT_MAX - OUT_MIN;
  localparam int RANGE_W   = $clog2(OUT_RANGE + 1);
  localparam int QW        = RANGE_W + 1;
  localparam int NUM_W     = DMAG_W + RANGE_W;
  localparam int CMP_W     = ((NUM_W > SMAG_W + QW) ? NUM_W : SMAG_W + QW) + 1;
  localparam int STEP_W    = $clog2(QW);

  // Stream widths, rounded up to whole bytes
  localparam int IN_DATA_W  = ((RAW_W + 7) / 8) * 8;
  localparam int OUT_BITS   = 2 * OUT_W + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIM    = 2'd0,
    REG_SPAN_LO = 2'd1,
    REG_SPAN_HI = 2'd2,
    REG_ALARM   = 2'd3
  } cfg_reg_t;

  // Input item kinds
  typedef enum logic [0:0] {
    ACT_SAMPLE  = 1'b0,
    ACT_RESTART = 1'b1
  } action_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic restart;
    logic mul;
    logic chk;
    logic div_step;
    logic upd;
  } bavg_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } bavg_sts_t;

endpackage

### src/bavg_ctrl.sv
// Sequencer for the battery average alarm: accept or restart, multiply, check, divide, update.
module bavg_ctrl import bavg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [0:0] in_tuser,
  input  bavg_sts_t  sts,
  output bavg_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_CHK  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_UPD  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              accept;
  action_t           action;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign action    = action_t'(in_tuser);

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (action == ACT_RESTART) begin
            cmd.restart = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        cmd.chk   = 1'b1;
        step_nxt  = STEP_W'(QW - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_UPD;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_UPD: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.upd   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

### src/bavg_dp.sv
// Datapath: config registers, linear mapping with serial divider, history ring, output.
module bavg_dp import bavg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bavg_cmd_t             cmd,
  output bavg_sts_t             sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic [RAW_W-1:0]      in_raw,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // Configuration registers
  logic signed [TRIM_W-1:0] trim_r;
  logic [SPAN_W-1:0]        span_lo_r;
  logic [SPAN_W-1:0]        span_hi_r;
  logic [OUT_W-1:0]         alarm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_r    <= '0;
      span_lo_r <= '0;
      span_hi_r <= SPAN_W'(OUT_MAX);
      alarm_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TRIM:    trim_r    <= $signed(cfg_wdata[TRIM_W-1:0]);
        REG_SPAN_LO: span_lo_r <= cfg_wdata[SPAN_W-1:0];
        REG_SPAN_HI: span_hi_r <= cfg_wdata[SPAN_W-1:0];
        REG_ALARM:   alarm_r   <= cfg_wdata[OUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Load: trimmed offset from span_low, and the signed span
  logic signed [D_W-1:0]   d_nxt, d_r;
  logic signed [DEN_W-1:0] den_nxt, den_r;

  assign d_nxt = $signed({2'b00, in_raw}) + D_W'(trim_r) - $signed({2'b00, span_lo_r});
  assign den_nxt = $signed({1'b0, span_hi_r}) - $signed({1'b0, span_lo_r});

  // Multiply: magnitudes, product with the output range, sign of the quotient
  logic [DMAG_W-1:0] d_mag;
  logic [NUM_W-1:0]  prod_nxt, prod_r;
  logic [SMAG_W-1:0] den_mag_r;
  logic              neg_r;
  logic              zero_r;

  assign d_mag    = DMAG_W'(d_r[D_W-1] ? -d_r : d_r);
  assign prod_nxt = {{RANGE_W{1'b0}}, d_mag} * {{DMAG_W{1'b0}}, RANGE_W'(OUT_RANGE)};

  // Divide: restoring, one quotient bit per cycle, overflow checked up front
  logic [CMP_W-1:0] rem_r;
  logic [CMP_W-1:0] div_r;
  logic [QW-1:0]    q_r;
  logic             ovf_r;
  logic             q_bit;

  assign q_bit = (rem_r >= div_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d_r   <= d_nxt;
      den_r <= den_nxt;
    end
    if (cmd.mul) begin
      prod_r    <= prod_nxt;
      den_mag_r <= SMAG_W'(den_r[DEN_W-1] ? -den_r : den_r);
      neg_r     <= d_r[D_W-1] ^ den_r[DEN_W-1];
      zero_r    <= (den_r == '0);
    end
    if (cmd.chk) begin
      rem_r <= CMP_W'(prod_r);
      div_r <= CMP_W'({den_mag_r, {(QW-1){1'b0}}});
      ovf_r <= (CMP_W'(prod_r) >= CMP_W'({den_mag_r, {QW{1'b0}}}));
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      if (q_bit) begin
        rem_r <= rem_r - div_r;
      end
      q_r   <= {q_r[QW-2:0], q_bit};
      div_r <= div_r >> 1;
    end
  end

  // Saturate the quotient into the output code range
  logic [OUT_W-1:0] scaled;

  always_comb begin
    priority if (zero_r) begin
      scaled = '0;
    end else if (neg_r) begin
      scaled = OUT_W'(OUT_MIN);
    end else if (ovf_r || (q_r > QW'(OUT_RANGE))) begin
      scaled = OUT_W'(OUT_MAX);
    end else begin
      scaled = OUT_W'(q_r) + OUT_W'(OUT_MIN);
    end
  end

  // History ring: entries not written since restart read as the fill level
  logic [OUT_W-1:0]   hist_mem [HISTORY_DEPTH];
  logic [OUT_W-1:0]   hist_rd_r;
  logic [HIST_AW-1:0] slot_r;
  logic               wrapped_r;
  logic [OUT_W-1:0]   fill_r;
  logic [SUM_W-1:0]   sum_r;
  logic [OUT_W-1:0]   oldest;
  logic [SUM_W-1:0]   sum_nxt;
  logic [OUT_W-1:0]   avg;

  assign oldest  = wrapped_r ? hist_rd_r : fill_r;
  assign sum_nxt = sum_r - SUM_W'(oldest) + SUM_W'(scaled);
  assign avg     = sum_nxt[SUM_W-1:HIST_AW];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hist_rd_r <= hist_mem[slot_r];
    end
    if (cmd.upd) begin
      hist_mem[slot_r] <= scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r    <= '0;
      wrapped_r <= 1'b0;
      fill_r    <= '0;
      sum_r     <= '0;
    end else if (cmd.restart) begin
      slot_r    <= '0;
      wrapped_r <= 1'b0;
      fill_r    <= alarm_r;
      sum_r     <= {alarm_r, {HIST_AW{1'b0}}};
    end else if (cmd.upd) begin
      sum_r <= sum_nxt;
      if (slot_r == HIST_AW'(HISTORY_DEPTH - 1)) begin
        slot_r    <= '0;
        wrapped_r <= 1'b1;
      end else begin
        slot_r <= slot_r + 1'b1;
      end
    end
  end

  // Output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.upd) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_data_r <= OUT_DATA_W'({(avg < alarm_r), avg, scaled});
    end
  end

endmodule

### src/battery_average_low_alarm_unit.sv
// Top level of the battery average low-level alarm.
// Each sample beat is trimmed, mapped from the calibration span onto codes OUT_MIN..OUT_MAX
// (saturated; a zero span gives 0), pushed into a 16-deep ring and averaged; the result beat
// carries the scaled value, the window average and a flag set when the average is below the
// alarm level. A restart beat refills the ring with the alarm level and gives no result. A
// sample runs through the 11-step serial restoring divider for the span; in_tready stays
// low meanwhile, so one sample is in work at a time. A finished result waits in an output
// register, and the next beat is taken while it waits. There is no clearing pass after
// reset: ring entries not yet written since reset or restart read as the fill level.
// Registers are to be written only while no beat is in work; the block does not enforce it.
module battery_average_low_alarm_unit import bavg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [9:0] raw_sample
  input  logic [0:0]            in_tuser,   // [0] action
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [9:0] scaled_value, [19:10] average_level,
                                            // [20] too_low
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  bavg_cmd_t cmd;
  bavg_sts_t sts;

  bavg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  bavg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_raw     (in_tdata[RAW_W-1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### src/bavg_chk.sv
// Port-level checker for the battery average alarm, bound to the top level.
module bavg_chk import bavg_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [0:0]            in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_W-1:0]      cfg_wdata
);

  // Shadow of the alarm level seen on the config port
  logic [OUT_W-1:0] alarm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_r <= '0;
    end else if (cfg_we && (cfg_index == REG_ALARM)) begin
      alarm_r <= cfg_wdata[OUT_W-1:0];
    end
  end

  // Flag agrees with the average and the last alarm level written
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2*OUT_W] == (out_tdata[2*OUT_W-1:OUT_W] < alarm_r)))
    else $error("too_low disagrees with average and alarm level");

  // A sample beat occupies the block: no beat taken on the next edge
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == ACT_SAMPLE)) |=> !in_tready)
    else $error("input taken while a sample is in work");

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result beat changed");

  // No result straight out of reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind battery_average_low_alarm_unit bavg_chk u_bavg_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_we     (cfg_we),
  .cfg_index  (cfg_index),
  .cfg_wdata  (cfg_wdata)
);

### tb/sv/battery_alarm_monitor.sv
// Result checker for the battery average alarm: predicts each result beat and compares it.
module battery_alarm_monitor import bavg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [9:0] raw_sample
  input  logic [0:0]            in_tuser,   // [0] action
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // [9:0] scaled_value, [19:10] average_level,
                                            // [20] too_low
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output int                    pending,
  output int                    errors
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [OUT_W-1:0] scaled;
    logic [OUT_W-1:0] average;
    logic             low;
  } reading_t;

  // Shadow copies of the calibration registers
  logic signed [TRIM_W-1:0] trim_q;
  logic [SPAN_W-1:0]        span_lo_q;
  logic [SPAN_W-1:0]        span_hi_q;
  logic [SPAN_W-1:0]        alarm_q;

  // Averaging window: ring, running total, slot of the oldest entry
  logic [OUT_W-1:0]   window [HISTORY_DEPTH];
  logic [SUM_W-1:0]   window_total;
  logic [HIST_AW-1:0] oldest_slot;

  reading_t due_readings [$];
  int       results_seen;

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Trim, map the span onto OUT_MIN..OUT_MAX (truncating toward zero), then clamp
  function automatic logic [OUT_W-1:0] map_sample(input logic [RAW_W-1:0] raw);
    int span;
    int offset;
    int code;
    span = int'(span_hi_q) - int'(span_lo_q);
    if (span == 0) return '0;
    offset = int'(raw) + int'(trim_q) - int'(span_lo_q);
    code = offset * OUT_RANGE / span + OUT_MIN;
    if (code < OUT_MIN) code = OUT_MIN;
    if (code > OUT_MAX) code = OUT_MAX;
    return code[OUT_W-1:0];
  endfunction

  // Advance the window model by one accepted input beat
  task automatic apply_beat(input action_t act, input logic [RAW_W-1:0] raw);
    logic [OUT_W-1:0] scaled;
    logic [OUT_W-1:0] average;
    if (act == ACT_RESTART) begin
      // refill every entry with the alarm level; no result
      foreach (window[i]) window[i] = alarm_q;
      window_total = SUM_W'(alarm_q) << HIST_AW;
      oldest_slot  = '0;
    end else begin
      scaled = map_sample(raw);
      window_total = window_total - window[oldest_slot] + scaled;
      window[oldest_slot] = scaled;
      oldest_slot = oldest_slot + 1'b1;  // wraps at the window depth
      average = OUT_W'(window_total >> HIST_AW);
      due_readings.push_back('{scaled, average, average < alarm_q});
    end
  endtask

  // Compare one result beat with the oldest expectation
  task automatic check_result(input logic [OUT_DATA_W-1:0] beat);
    reading_t         want;
    logic [OUT_W-1:0] got_scaled;
    logic [OUT_W-1:0] got_average;
    logic             got_low;
    got_scaled  = beat[OUT_W-1:0];
    got_average = beat[2*OUT_W-1:OUT_W];
    got_low     = beat[2*OUT_W];
    results_seen++;
    if (due_readings.size() == 0) begin
      report_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                results_seen));
    end else begin
      want = due_readings.pop_front();
      if (got_scaled !== want.scaled)
        report_mismatch($sformatf("beat %0d scaled_value %0d, expected %0d",
                                  results_seen, got_scaled, want.scaled));
      if (got_average !== want.average)
        report_mismatch($sformatf("beat %0d average_level %0d, expected %0d",
                                  results_seen, got_average, want.average));
      if (got_low !== want.low)
        report_mismatch($sformatf("beat %0d too_low %0b, expected %0b",
                                  results_seen, got_low, want.low));
    end
  endtask

  // Watch all three ports at each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      trim_q       = '0;
      span_lo_q    = '0;
      span_hi_q    = '1;
      alarm_q      = '0;
      foreach (window[i]) window[i] = '0;
      window_total = '0;
      oldest_slot  = '0;
      due_readings.delete();
      results_seen = 0;
      errors       = 0;
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (in_tvalid && in_tready) apply_beat(action_t'(in_tuser), in_tdata[RAW_W-1:0]);
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_TRIM:    trim_q    = cfg_wdata[TRIM_W-1:0];
          REG_SPAN_LO: span_lo_q = cfg_wdata[SPAN_W-1:0];
          REG_SPAN_HI: span_hi_q = cfg_wdata[SPAN_W-1:0];
          REG_ALARM:   alarm_q   = cfg_wdata[SPAN_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= due_readings.size();
  end

endmodule

### tb/sv/tb_battery_average_low_alarm_unit.sv
// Testbench top for the battery average alarm: clock, reset, stimulus and verdict.
module tb_battery_average_low_alarm_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import bavg_pkg::*;

  localparam int CLK_PERIOD    = 8;
  localparam int SETTLE_CYCLES = 20;    // covers a restart or sample still in work
  localparam int STALL_LIMIT   = 2000;
  localparam int SEGMENTS      = 8;
  localparam int SEGMENT_BEATS = 39;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [9:0] raw_sample
  logic [0:0]            in_tuser   = '0;   // [0] action
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [9:0] scaled_value, [19:10] average_level,
                                            // [20] too_low
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_W-1:0]      cfg_wdata  = '0;

  int pending;
  int errors;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int span_lo_cur = 0;
  int span_hi_cur = 1023;

  always #(CLK_PERIOD / 2) clk = ~clk;

  battery_average_low_alarm_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  battery_alarm_monitor monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .errors     (errors)
  );

  // Receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Offer one beat, with random gaps, and hold it until accepted
  task automatic push_beat(input action_t act, input logic [RAW_W-1:0] raw);
    if (tx_idle_pct != 0 && $urandom_range(19) == 0) begin
      // occasional longer gap so it lands at different points of a sample in work
      in_tvalid <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk);
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= IN_DATA_W'(raw);
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending, wait for every expected result, then let the block go idle
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four calibration registers back to back
  task automatic program_regs(input int trim, input int lo, input int hi, input int level);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TRIM;
    cfg_wdata <= CFG_W'(trim);
    @(posedge clk);
    cfg_index <= REG_SPAN_LO;
    cfg_wdata <= CFG_W'(lo);
    @(posedge clk);
    cfg_index <= REG_SPAN_HI;
    cfg_wdata <= CFG_W'(hi);
    @(posedge clk);
    cfg_index <= REG_ALARM;
    cfg_wdata <= CFG_W'(level);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Pick a calibration: full, reversed, zero or random span; extreme or random trim
  task automatic random_setting();
    int trim;
    int level;
    case ($urandom_range(5))
      0: begin span_lo_cur = 0; span_hi_cur = 1023; end
      1: begin span_lo_cur = 1023; span_hi_cur = 0; end
      2: begin span_lo_cur = $urandom_range(1023); span_hi_cur = span_lo_cur; end
      default: begin
        span_lo_cur = $urandom_range(1023);
        span_hi_cur = $urandom_range(1023);
      end
    endcase
    case ($urandom_range(3))
      0: trim = 0;
      1: trim = ($urandom_range(1) == 0) ? 1023 : -1023;
      2: trim = int'($urandom_range(128)) - 64;
      default: trim = int'($urandom_range(2046)) - 1023;
    endcase
    case ($urandom_range(3))
      0: level = 0;
      1: level = 1023;
      default: level = $urandom_range(1023);
    endcase
    program_regs(trim, span_lo_cur, span_hi_cur, level);
  endtask

  // Mostly samples, half of them inside the current span; a restart now and then
  task automatic random_beat();
    logic [RAW_W-1:0] raw;
    if ($urandom_range(1) == 0) raw = RAW_W'($urandom);
    else raw = RAW_W'($urandom_range(span_lo_cur, span_hi_cur));
    if ($urandom_range(15) == 0) push_beat(ACT_RESTART, raw);
    else push_beat(ACT_SAMPLE, raw);
  endtask

  // Watchdog on cycles with no beat moving on either stream
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    tx_idle_pct = 31;
    rx_idle_pct = 52;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset calibration: full span, no trim, alarm at zero
    push_beat(ACT_SAMPLE, 10'd0);
    push_beat(ACT_SAMPLE, 10'd1023);
    push_beat(ACT_SAMPLE, 10'd512);
    push_beat(ACT_RESTART, 10'd1023);
    push_beat(ACT_SAMPLE, 10'd700);
    settle();

    // most negative trim clamps at the bottom; alarm at the top code
    program_regs(-1023, 0, 1023, 1023);
    push_beat(ACT_SAMPLE, 10'd0);
    push_beat(ACT_SAMPLE, 10'd1023);
    push_beat(ACT_RESTART, 10'd0);
    push_beat(ACT_SAMPLE, 10'd1023);
    settle();

    // most positive trim clamps at the top
    program_regs(1023, 0, 1023, 0);
    push_beat(ACT_SAMPLE, 10'd1023);
    push_beat(ACT_SAMPLE, 10'd0);
    settle();

    // zero span: every sample maps to zero
    program_regs(0, 500, 500, 300);
    push_beat(ACT_SAMPLE, 10'd0);
    push_beat(ACT_SAMPLE, 10'd1023);
    settle();

    // fully reversed span
    program_regs(0, 1023, 0, 512);
    push_beat(ACT_SAMPLE, 10'd0);
    push_beat(ACT_SAMPLE, 10'd1023);
    push_beat(ACT_SAMPLE, 10'd600);
    settle();

    // partial reversed span with negative offsets truncating toward zero
    program_regs(-5, 700, 300, 512);
    push_beat(ACT_RESTART, 10'd0);
    push_beat(ACT_SAMPLE, 10'd450);
    push_beat(ACT_SAMPLE, 10'd800);
    push_beat(ACT_SAMPLE, 10'd0);

    // random segments under three idling mixes
    for (int ph = 0; ph < 3; ph++) begin
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        settle();
        case (ph)
          0: begin tx_idle_pct = 31; rx_idle_pct = 52; end
          1: begin tx_idle_pct = 52; rx_idle_pct = 31; end
          default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
        endcase
        random_setting();
        repeat (SEGMENT_BEATS) random_beat();
      end
    end
    settle();

    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
